[hw/rtl/stq_pkg.sv]
// stq_pkg: shared types and constants for the sorted timer queue.
// Used by stq_cell and sorted_timer_queue; depends on nothing.
`default_nettype none

package stq_pkg;

    // operation codes of the input channel
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_SET   = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [7:0] TTN_CAP    = 8'hFF;
    localparam int         SLOT_COUNT = 16;

    typedef struct packed {
        logic        valid;
        logic [31:0] deadline;
        logic [3:0]  slot;
    } entry_t;

    localparam entry_t ENTRY_EMPTY = '{valid: 1'b0, deadline: 32'd0, slot: 4'd0};

    typedef enum logic [1:0] {
        CMD_HOLD   = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_REMOVE = 2'd2
    } cmd_mode_t;

    // broadcast to every cell of the chain
    typedef struct packed {
        cmd_mode_t   mode;
        logic        pop;       // remove the head entry
        logic [31:0] now;       // current time
        logic [30:0] interval;  // set: ticks until expiry
        logic [31:0] deadline;  // set: now + interval
        logic [3:0]  slot;      // set/clear slot
    } cell_cmd_t;

endpackage

`default_nettype wire

[hw/rtl/sorted_timer_queue.sv]
// sorted_timer_queue: top level; control, time counter and a chain of stq_cell.
// Depends on stq_pkg and stq_cell.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------------------
//  in      | input     | in_valid / in_ready  | operation, slot, interval
//  out     | output    | out_valid / out_ready| status, expired_valid, expired_slot,
//          |           |                      | ticks_to_next, last
//
// Set and clear: the transfer, then an execute state in which the cell chain
// inserts or removes in place; the result goes to the waiting result register,
// then to the output register, while the next item may already transfer in.
// A tick with nothing expired takes the same steps as a set; with expiries the
// execute state repeats a pop per expired entry: each pop shifts the whole chain by one
// cell, so expiries leave at one result per cycle while the output is not stalled.
// Reset clears time, the pending flags and the cell valid bits at once; no
// clearing pass. A stalled output holds the chain until the result register frees.
`default_nettype none

module sorted_timer_queue
    import stq_pkg::*;
#(
    parameter int NUM_TIMERS = 16
)
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    output logic        in_ready,
    input  wire  [1:0]  operation,
    input  wire  [3:0]  slot,
    input  wire  [30:0] interval,
    output logic        out_valid,
    input  wire         out_ready,
    output logic        status,
    output logic        expired_valid,
    output logic [3:0]  expired_slot,
    output logic [7:0]  ticks_to_next,
    output logic        last
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t      state_reg, state_next;
    logic [1:0]  op_reg;
    logic [3:0]  slot_reg;
    logic [30:0] interval_reg;
    logic [31:0] time_reg, time_next;
    logic [SLOT_COUNT-1:0] pending_reg, pending_next;

    // result waiting for the output register; ticks_to_next is taken at load
    logic        rep_pend_reg, rep_pend_next;
    logic        rep_status_reg, rep_status_next;
    logic        rep_xv_reg, rep_xv_next;
    logic [3:0]  rep_xslot_reg, rep_xslot_next;
    logic        rep_last_reg, rep_last_next;

    logic        out_valid_reg;
    logic        status_reg, xv_reg, last_reg;
    logic [3:0]  xslot_reg;
    logic [7:0]  ttn_reg, ttn_calc;

    logic        in_xfer, load_out, can_rep;
    logic [31:0] head_dist;
    logic        head_exp, next_exp, queue_full, set_refused;
    cell_cmd_t   cmd;

    entry_t                ent  [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] xp;
    logic [NUM_TIMERS-1:0] vld;
    logic [NUM_TIMERS:0]   fnd;

    // ---------------- cell chain ----------------
    assign fnd[0] = cmd.pop;

    for (genvar i = 0; i < NUM_TIMERS; i++)
    begin : g_cell
        entry_t left_in, right_in;
        if (i == 0)
        begin : g_head
            assign left_in = ENTRY_EMPTY;
        end
        else
        begin : g_mid_l
            assign left_in = ent[i-1];
        end
        if (i == NUM_TIMERS - 1)
        begin : g_tail
            assign right_in = ENTRY_EMPTY;
        end
        else
        begin : g_mid_r
            assign right_in = ent[i+1];
        end

        stq_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cmd),
            .left      (left_in),
            .right     (right_in),
            .found_in  (fnd[i]),
            .found_out (fnd[i+1]),
            .ent       (ent[i]),
            .expired   (xp[i])
        );
        assign vld[i] = ent[i].valid;
    end

    if (NUM_TIMERS > 1)
    begin : g_next
        assign next_exp = xp[1];
    end
    else
    begin : g_single
        assign next_exp = 1'b0;
    end

    assign head_exp   = xp[0];
    assign queue_full = ent[NUM_TIMERS-1].valid;
    assign set_refused = ({28'd0, slot_reg} >= 32'(NUM_TIMERS)) ||
                         pending_reg[slot_reg] || queue_full;

    // ---------------- handshakes ----------------
    assign load_out = rep_pend_reg && (!out_valid_reg || out_ready);
    assign can_rep  = !rep_pend_reg || load_out;
    assign in_ready = (state_reg == ST_IDLE) && can_rep;
    assign in_xfer  = in_valid && in_ready;

    // distance to the head deadline, clipped to 0..255
    assign head_dist = ent[0].deadline - time_reg;
    always_comb
    begin
        if (!ent[0].valid)
            ttn_calc = TTN_CAP;
        else if ((head_dist == 32'd0) || head_dist[31])
            ttn_calc = 8'd0;
        else if (head_dist >= {24'd0, TTN_CAP})
            ttn_calc = TTN_CAP;
        else
            ttn_calc = head_dist[7:0];
    end

    // ---------------- control ----------------
    always_comb
    begin
        state_next      = state_reg;
        time_next       = time_reg;
        pending_next    = pending_reg;
        rep_pend_next   = rep_pend_reg & ~load_out;
        rep_status_next = rep_status_reg;
        rep_xv_next     = rep_xv_reg;
        rep_xslot_next  = rep_xslot_reg;
        rep_last_next   = rep_last_reg;

        cmd.mode     = CMD_HOLD;
        cmd.pop      = 1'b0;
        cmd.now      = time_reg;
        cmd.interval = interval_reg;
        cmd.deadline = time_reg + {1'b0, interval_reg};
        cmd.slot     = slot_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = ST_EXEC;
                    if (operation == OP_TICK)
                        time_next = time_reg + 32'd1;
                end
            end
            ST_EXEC:
            begin
                if (can_rep)
                begin
                    rep_pend_next   = 1'b1;
                    rep_status_next = 1'b0;
                    rep_xv_next     = 1'b0;
                    rep_xslot_next  = 4'd0;
                    rep_last_next   = 1'b1;
                    state_next      = ST_IDLE;
                    case (op_reg)
                        OP_TICK:
                        begin
                            if (head_exp)
                            begin
                                cmd.mode       = CMD_REMOVE;
                                cmd.pop        = 1'b1;
                                pending_next[ent[0].slot] = 1'b0;
                                rep_xv_next    = 1'b1;
                                rep_xslot_next = ent[0].slot;
                                rep_last_next  = !next_exp;
                                if (next_exp)
                                    state_next = ST_EXEC;
                            end
                        end
                        OP_SET:
                        begin
                            if (set_refused)
                                rep_status_next = 1'b1;
                            else
                            begin
                                cmd.mode = CMD_INSERT;
                                pending_next[slot_reg] = 1'b1;
                            end
                        end
                        OP_CLEAR:
                        begin
                            if (pending_reg[slot_reg])
                            begin
                                cmd.mode = CMD_REMOVE;
                                pending_next[slot_reg] = 1'b0;
                            end
                        end
                        default:
                        begin
                            rep_status_next = 1'b0;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            time_reg      <= 32'd0;
            pending_reg   <= '0;
            rep_pend_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            time_reg     <= time_next;
            pending_reg  <= pending_next;
            rep_pend_reg <= rep_pend_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            op_reg       <= operation;
            slot_reg     <= slot;
            interval_reg <= interval;
        end
        rep_status_reg <= rep_status_next;
        rep_xv_reg     <= rep_xv_next;
        rep_xslot_reg  <= rep_xslot_next;
        rep_last_reg   <= rep_last_next;
        if (load_out)
        begin
            status_reg <= rep_status_reg;
            xv_reg     <= rep_xv_reg;
            xslot_reg  <= rep_xslot_reg;
            last_reg   <= rep_last_reg;
            ttn_reg    <= ttn_calc;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign expired_valid = xv_reg;
    assign expired_slot  = xslot_reg;
    assign ticks_to_next = ttn_reg;
    assign last          = last_reg;

`ifndef SYNTHESIS
    // the number of pending slots equals the number of occupied cells
    a_pending_matches_cells: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(pending_reg) == $countones(vld))
        else $error("pending flags disagree with occupied cells");

    // occupied cells form an unbroken run from the head
    a_chain_packed: assert property (@(posedge clk) disable iff (!rst_n)
        (vld & (vld + 1'b1)) == '0)
        else $error("gap in the cell chain");

    // a pop only removes a head that has reached its deadline
    a_pop_expired: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> (ent[0].valid && head_exp))
        else $error("pop of a head that has not expired");

    // a reported expiry is never a refused set
    a_expiry_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && expired_valid) |-> !status)
        else $error("expiry result with error status");
`endif

endmodule

`default_nettype wire

[hw/rtl/stq_cell.sv]
// stq_cell: one queue position; holds an entry and shifts to/from neighbors.
// Depends on stq_pkg.
`default_nettype none

module stq_cell
    import stq_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    input  cell_cmd_t   cmd,
    input  entry_t      left,
    input  entry_t      right,
    input  wire         found_in,
    output logic        found_out,
    output entry_t      ent,
    output logic        expired
);

    logic        valid_reg, valid_next;
    logic [31:0] dl_reg, dl_next;
    logic [3:0]  sl_reg, sl_next;
    logic [31:0] delta;
    logic        hit_set, hit_clr;

    assign delta   = dl_reg - cmd.now;
    assign expired = valid_reg && ((delta == 32'd0) || delta[31]);

    // set goes before the first entry strictly later than the new deadline,
    // or into the first empty position
    assign hit_set = !valid_reg ||
                     ((delta != 32'd0) && !delta[31] && ({1'b0, cmd.interval} < delta));
    assign hit_clr = valid_reg && (sl_reg == cmd.slot) && !cmd.pop;

    always_comb
    begin
        valid_next = valid_reg;
        dl_next    = dl_reg;
        sl_next    = sl_reg;
        found_out  = found_in;
        case (cmd.mode)
            CMD_INSERT:
            begin
                found_out = found_in | hit_set;
                if (found_in)
                begin
                    valid_next = left.valid;
                    dl_next    = left.deadline;
                    sl_next    = left.slot;
                end
                else if (hit_set)
                begin
                    valid_next = 1'b1;
                    dl_next    = cmd.deadline;
                    sl_next    = cmd.slot;
                end
            end
            CMD_REMOVE:
            begin
                found_out = found_in | hit_clr;
                if (found_in || hit_clr)
                begin
                    valid_next = right.valid;
                    dl_next    = right.deadline;
                    sl_next    = right.slot;
                end
            end
            default:
            begin
                found_out = found_in;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        dl_reg <= dl_next;
        sl_reg <= sl_next;
    end

    assign ent = '{valid: valid_reg, deadline: dl_reg, slot: sl_reg};

endmodule

`default_nettype wire
